// ----- rtl/checksummed_packet_receiver_assert.svh -----
// assertion macros shared by the rtl
`ifndef CHECKSUMMED_PACKET_RECEIVER_ASSERT_SVH
`define CHECKSUMMED_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define CPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cpr_pkg.sv -----
package cpr_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LENGTH,
		PH_DATA,
		PH_CHECK,
		PH_DRAIN
	} phase_t;

	localparam logic [7:0] CODE_ACK   = 8'hFD;
	localparam logic [7:0] CODE_NACK  = 8'hFE;
	localparam logic [7:0] CODE_START = 8'h02;

	localparam logic KIND_REPLY   = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

endpackage

// ----- rtl/cpr_payload_ram.sv -----
module cpr_payload_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds its data while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/checksummed_packet_receiver.sv -----
// checksummed packet receiver: start / length / payload / checksum deframer
//
// s_axis carries one received serial byte per item in tdata. m_axis carries the
// results: tdata is the reply code (ack 0xFD, nack 0xFE) or a payload byte,
// tuser is 0 for a reply and 1 for a payload byte, tlast marks the final result
// caused by one input byte.
// a frame is start byte 0x02, a length byte (0 .. BUFFER_DEPTH), that many
// payload bytes and a checksum byte; the frame checks when length plus payload
// plus checksum sums to zero modulo 256. payload bytes are kept in a single-port
// write / single-port read memory with a registered read.
// a reply is registered and is on m_axis in the cycle after the byte causing it.
// bytes that give no result or a single reply are taken at one per cycle while
// the output register is free. a good checksum gives the ack and then streams
// the payload out of the memory at one item per cycle while m_axis takes them;
// s_axis tready stays low while the payload drains.
// a one-entry output register sits on m_axis; when m_axis stalls the register
// holds its item and s_axis tready drops until it is taken, no data is lost.
// reset (arst_n low) returns to idle and empties the output register; the payload
// memory needs no clearing since it is only read after the current frame wrote it

`include "checksummed_packet_receiver_assert.svh"

module checksummed_packet_receiver #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	// result stream
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tuser,   // [0] item_kind
	output logic       m_axis_tlast    // last_of_run
);

	// memory address width and count width (count must reach BUFFER_DEPTH)
	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [7:0] DEPTH_BYTE = 8'(BUFFER_DEPTH);

	cpr_pkg::phase_t phase_q, phase_d;

	logic [CW-1:0] frame_length_q;
	logic [CW-1:0] fill_position_q;
	logic [7:0]    running_sum_q;
	logic [CW-1:0] rd_addr_q;      // next payload entry to read during drain
	logic          rd_pending_q;   // memory read data holds an unsent payload byte

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_kind_q;
	logic       out_last_q;

	logic          out_free;
	logic          in_fire;
	logic [CW-1:0] fill_next;
	logic [7:0]    sum_next;
	logic          sum_match;
	logic          len_too_big;

	// control decoded from the phase
	logic       res_valid;
	logic [7:0] res_byte;
	logic       res_last;
	logic       drain_load;
	logic       drain_last;
	logic       rd_issue;
	logic       mem_wr;
	logic [7:0] mem_rd_data;

	assign out_free    = !out_valid_q || m_axis_tready;
	assign in_fire     = s_axis_tvalid && s_axis_tready;
	assign fill_next   = fill_position_q + CW'(1);
	assign sum_next    = 8'(running_sum_q + s_axis_tdata);
	assign sum_match   = (sum_next == 8'd0);
	assign len_too_big = (s_axis_tdata > DEPTH_BYTE);

	// the outstanding read always targets rd_addr_q - 1, so the byte in the memory
	// register is the final one once every entry has been requested
	assign drain_last = (rd_addr_q == frame_length_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			cpr_pkg::PH_IDLE: begin
				if (in_fire && s_axis_tdata == cpr_pkg::CODE_START) begin
					phase_d = cpr_pkg::PH_LENGTH;
				end
			end
			cpr_pkg::PH_LENGTH: begin
				if (in_fire) begin
					priority if (len_too_big) begin
						phase_d = cpr_pkg::PH_IDLE;
					end else if (s_axis_tdata == 8'd0) begin
						phase_d = cpr_pkg::PH_CHECK;
					end else begin
						phase_d = cpr_pkg::PH_DATA;
					end
				end
			end
			cpr_pkg::PH_DATA: begin
				if (in_fire && fill_next == frame_length_q) begin
					phase_d = cpr_pkg::PH_CHECK;
				end
			end
			cpr_pkg::PH_CHECK: begin
				if (in_fire) begin
					if (sum_match && frame_length_q != '0) begin
						phase_d = cpr_pkg::PH_DRAIN;
					end else begin
						phase_d = cpr_pkg::PH_IDLE;
					end
				end
			end
			cpr_pkg::PH_DRAIN: begin
				if (drain_load && drain_last) begin
					phase_d = cpr_pkg::PH_IDLE;
				end
			end
			default: phase_d = cpr_pkg::PH_IDLE;
		endcase
	end

	// phase outputs
	always_comb begin
		s_axis_tready = 1'b0;
		res_valid     = 1'b0;
		res_byte      = cpr_pkg::CODE_NACK;
		res_last      = 1'b1;
		drain_load    = 1'b0;
		rd_issue      = 1'b0;
		mem_wr        = 1'b0;
		unique case (phase_q)
			cpr_pkg::PH_IDLE: begin
				s_axis_tready = out_free;
				res_valid     = in_fire && (s_axis_tdata != cpr_pkg::CODE_START);
			end
			cpr_pkg::PH_LENGTH: begin
				s_axis_tready = out_free;
				res_valid     = in_fire && len_too_big;
			end
			cpr_pkg::PH_DATA: begin
				s_axis_tready = out_free;
				mem_wr        = in_fire;
			end
			cpr_pkg::PH_CHECK: begin
				s_axis_tready = out_free;
				res_valid     = in_fire;
				if (sum_match) begin
					res_byte = cpr_pkg::CODE_ACK;
					res_last = (frame_length_q == '0);
				end
			end
			cpr_pkg::PH_DRAIN: begin
				drain_load = rd_pending_q && out_free;
				rd_issue   = !drain_last && (!rd_pending_q || drain_load);
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= cpr_pkg::PH_IDLE;
			frame_length_q  <= '0;
			fill_position_q <= '0;
			running_sum_q   <= '0;
			rd_addr_q       <= '0;
			rd_pending_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (in_fire) begin
				unique case (phase_q)
					cpr_pkg::PH_LENGTH: begin
						frame_length_q  <= len_too_big ? '0 : s_axis_tdata[CW-1:0];
						running_sum_q   <= len_too_big ? '0 : s_axis_tdata;
						fill_position_q <= '0;
						rd_addr_q       <= '0;
					end
					cpr_pkg::PH_DATA: begin
						fill_position_q <= fill_next;
						running_sum_q   <= sum_next;
					end
					cpr_pkg::PH_CHECK: begin
						// keep the length for the drain, clear the rest
						fill_position_q <= '0;
						running_sum_q   <= '0;
						if (!(sum_match && frame_length_q != '0)) begin
							frame_length_q <= '0;
						end
					end
					default: begin
						running_sum_q <= running_sum_q;
					end
				endcase
			end
			if (rd_issue) begin
				rd_addr_q <= rd_addr_q + CW'(1);
			end
			if (rd_issue) begin
				rd_pending_q <= 1'b1;
			end else if (drain_load) begin
				rd_pending_q <= 1'b0;
			end
			if (drain_load && drain_last) begin
				frame_length_q <= '0;
				rd_addr_q      <= '0;
			end
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid || drain_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (drain_load) begin
			out_byte_q <= mem_rd_data;
			out_kind_q <= cpr_pkg::KIND_PAYLOAD;
			out_last_q <= drain_last;
		end else if (res_valid) begin
			out_byte_q <= res_byte;
			out_kind_q <= cpr_pkg::KIND_REPLY;
			out_last_q <= res_last;
		end
	end

	cpr_payload_ram #(
		.DEPTH (BUFFER_DEPTH),
		.AW    (AW)
	) u_payload_ram (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (fill_position_q[AW-1:0]),
		.wr_data (s_axis_tdata),
		.rd_en   (rd_issue),
		.rd_addr (rd_addr_q[AW-1:0]),
		.rd_data (mem_rd_data)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	// a read is outstanding only while draining a frame
	`CPR_ASSERT_NOW(a_pending_in_drain, clk, arst_n, rd_pending_q, phase_q == cpr_pkg::PH_DRAIN, "payload read outstanding outside drain")
	// a drain always has something to send
	`CPR_ASSERT_NOW(a_drain_nonempty, clk, arst_n, phase_q == cpr_pkg::PH_DRAIN, frame_length_q != '0, "drain with zero length")
	// the byte handed out always comes from a requested entry
	`CPR_ASSERT_NOW(a_load_after_read, clk, arst_n, drain_load, rd_addr_q != '0, "payload loaded without a read")
	// filling never passes the announced length
	`CPR_ASSERT_NOW(a_fill_bound, clk, arst_n, phase_q == cpr_pkg::PH_DATA, fill_position_q < frame_length_q, "payload fill past frame length")
	// after the final payload byte is loaded the block is idle again
	`CPR_ASSERT_NEXT(a_drain_ends, clk, arst_n, drain_load && drain_last, phase_q == cpr_pkg::PH_IDLE, "drain did not end on last byte")

endmodule

// ----- tb/sv/checksummed_packet_receiver_test.sv -----
`timescale 1ns / 100ps

// frames are built with random payloads and good or corrupted checksums,
// mixed with stray bytes, oversize lengths and cut-off frames; a deframer
// model predicts the replies and the delivered payload, and every item
// leaving the block is checked against the oldest prediction
module checksummed_packet_receiver_test;

	localparam int DEPTH = 32;
	localparam int RANDOM_ITEMS = 180;
	// consecutive cycles with no item moving on either side
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tuser;
	logic       m_axis_tlast;

	checksummed_packet_receiver #(
		.BUFFER_DEPTH(DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// serial bytes waiting to be sent, and replies the block still owes
	logic [7:0] rx_bytes[$];
	reply_t     expected_replies[$];
	int         error_count = 0;

	// deframer state as the block should hold it
	cpr_pkg::phase_t rx_phase = cpr_pkg::PH_IDLE;
	logic [5:0] frame_len = '0;
	logic [5:0] fill_pos = '0;
	logic [7:0] running_sum = '0;
	logic [7:0] payload_mem[DEPTH];

	task automatic flag_mismatch(string what);
		error_count++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	function automatic void queue_reply(logic kind, logic [7:0] data, logic last);
		reply_t r;
		r.kind = kind;
		r.data = data;
		r.last = last;
		expected_replies.push_back(r);
	endfunction

	function automatic void drop_frame();
		rx_phase = cpr_pkg::PH_IDLE;
		frame_len = '0;
		fill_pos = '0;
		running_sum = '0;
	endfunction

	// one received byte in, the items it should cause queued
	function automatic void deframe_byte(logic [7:0] b);
		case (rx_phase)
			cpr_pkg::PH_IDLE: begin
				if (b == cpr_pkg::CODE_START)
					rx_phase = cpr_pkg::PH_LENGTH;
				else
					queue_reply(cpr_pkg::KIND_REPLY, cpr_pkg::CODE_NACK, 1'b1);
			end
			cpr_pkg::PH_LENGTH: begin
				if (b > DEPTH) begin
					queue_reply(cpr_pkg::KIND_REPLY, cpr_pkg::CODE_NACK, 1'b1);
					drop_frame();
				end else begin
					frame_len = b[5:0];
					fill_pos = '0;
					running_sum = b;
					rx_phase = (b == 8'd0) ? cpr_pkg::PH_CHECK : cpr_pkg::PH_DATA;
				end
			end
			cpr_pkg::PH_DATA: begin
				payload_mem[fill_pos[4:0]] = b;
				fill_pos++;
				running_sum += b;
				if (fill_pos >= frame_len)
					rx_phase = cpr_pkg::PH_CHECK;
			end
			cpr_pkg::PH_CHECK: begin
				// length + payload + checksum must wrap to zero
				if (8'(running_sum + b) == 8'd0) begin
					queue_reply(cpr_pkg::KIND_REPLY, cpr_pkg::CODE_ACK, frame_len == 0);
					for (int i = 0; i < frame_len; i++)
						queue_reply(cpr_pkg::KIND_PAYLOAD, payload_mem[i],
							i + 1 == frame_len);
				end else begin
					queue_reply(cpr_pkg::KIND_REPLY, cpr_pkg::CODE_NACK, 1'b1);
				end
				drop_frame();
			end
			default: drop_frame();
		endcase
	endfunction

	// start, length, random payload, then a checksum that matches or not
	task automatic add_frame(int len, bit good);
		logic [7:0] sum;
		logic [7:0] p;
		sum = 8'(len);
		rx_bytes.push_back(cpr_pkg::CODE_START);
		rx_bytes.push_back(8'(len));
		for (int i = 0; i < len; i++) begin
			p = 8'($urandom_range(0, 255));
			sum += p;
			rx_bytes.push_back(p);
		end
		if (good)
			rx_bytes.push_back(8'(0) - sum);
		else
			rx_bytes.push_back((8'(0) - sum) ^ 8'($urandom_range(1, 255)));
	endtask

	// sender: bursts of random length separated by random gaps
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				deframe_byte(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					s_axis_tvalid <= 1'b0;
					gap_left--;
				end else if (rx_bytes.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= rx_bytes.pop_front();
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						// a third of the bursts run straight into the next
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern switches between calm, light and heavy stretches
	int rx_mode = 0;
	int mode_timer = 0;
	int stall_left = 0;

	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_replies.size() == 0) begin
					flag_mismatch($sformatf("unexpected item kind %0b byte %02h last %0b",
						m_axis_tuser, m_axis_tdata, m_axis_tlast));
				end else begin
					want = expected_replies.pop_front();
					if (m_axis_tuser !== want.kind)
						flag_mismatch($sformatf("kind %0b, expected %0b", m_axis_tuser, want.kind));
					if (m_axis_tdata !== want.data)
						flag_mismatch($sformatf("byte %02h, expected %02h", m_axis_tdata, want.data));
					if (m_axis_tlast !== want.last)
						flag_mismatch($sformatf("last %0b, expected %0b", m_axis_tlast, want.last));
				end
			end
			if (mode_timer == 0) begin
				rx_mode = $urandom_range(0, 2);
				mode_timer = $urandom_range(20, 120);
			end else begin
				mode_timer--;
			end
			if (stall_left != 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				case (rx_mode)
					1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 4);
					2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 12);
					default: stall_left = 0;
				endcase
			end
		end
	end

	// watchdog on cycles with no item moving
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		int len;
		int cut;

		// stray bytes in idle get a nack
		rx_bytes.push_back(8'h00);
		rx_bytes.push_back(8'hFF);
		// empty frame, good and bad checksum
		add_frame(0, 1'b1);
		add_frame(0, 1'b0);
		// lengths past the buffer are refused at once
		rx_bytes.push_back(cpr_pkg::CODE_START);
		rx_bytes.push_back(8'(DEPTH + 1));
		rx_bytes.push_back(cpr_pkg::CODE_START);
		rx_bytes.push_back(8'hFF);
		// one byte of 0xff, sum wraps to a zero checksum
		rx_bytes.push_back(cpr_pkg::CODE_START);
		rx_bytes.push_back(8'h01);
		rx_bytes.push_back(8'hFF);
		rx_bytes.push_back(8'h00);
		// start and ack codes inside the payload, wrong checksum
		rx_bytes.push_back(cpr_pkg::CODE_START);
		rx_bytes.push_back(8'h02);
		rx_bytes.push_back(cpr_pkg::CODE_START);
		rx_bytes.push_back(cpr_pkg::CODE_ACK);
		rx_bytes.push_back(8'h00);

		// a full-size frame early on, then the random mix up to the item count
		add_frame(DEPTH, 1'b1);
		while (rx_bytes.size() < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				case ($urandom_range(0, 9))
					0: len = 0;
					1: len = DEPTH;
					2: len = $urandom_range(9, DEPTH - 1);
					default: len = $urandom_range(1, 8);
				endcase
				add_frame(len, $urandom_range(0, 4) != 0);
			end else if (pick < 85) begin
				rx_bytes.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 92) begin
				rx_bytes.push_back(cpr_pkg::CODE_START);
				rx_bytes.push_back(8'($urandom_range(DEPTH + 1, 255)));
			end else begin
				// frame cut short; what follows is taken as its payload
				len = $urandom_range(2, 8);
				cut = $urandom_range(0, len - 1);
				rx_bytes.push_back(cpr_pkg::CODE_START);
				rx_bytes.push_back(8'(len));
				for (int i = 0; i < cut; i++)
					rx_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_bytes.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
